>>> hw/rtl/qte_pkg.sv
// qte_pkg: shared types, widths, constants and the arctangent table for the
// quaternion to Euler heading core. No dependencies.
package qte_pkg;

  // Angle unit iterations, capped at the table depth
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITERS = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;

  localparam int QW      = 16;   // quaternion component width
  localparam int PW      = 32;   // component product width
  localparam int SW      = 35;   // sum-of-products width
  localparam int CW      = 38;   // CORDIC x/y width
  localparam int ZW      = 33;   // CORDIC angle accumulator, Q16 centidegrees
  localparam int AW      = 17;   // rounded angle width
  localparam int CNT_W   = 6;
  localparam int NUM_PROD  = 10;
  localparam int MUL_STEPS = 32;
  localparam int SQRT_STEPS = 32;

  localparam logic [16:0] FULL_TURN   = 17'd36000;
  localparam logic signed [ZW-1:0] HALF_TURN_Q16 = 33'sd1179648000;

  // Accuracy status of a fully calibrated sensor
  localparam logic [1:0] ACC_FULL = 2'd3;

  // Product slots
  localparam logic [3:0] PRD_WW = 4'd0;
  localparam logic [3:0] PRD_XX = 4'd1;
  localparam logic [3:0] PRD_YY = 4'd2;
  localparam logic [3:0] PRD_ZZ = 4'd3;
  localparam logic [3:0] PRD_XY = 4'd4;
  localparam logic [3:0] PRD_ZW = 4'd5;
  localparam logic [3:0] PRD_XZ = 4'd6;
  localparam logic [3:0] PRD_YW = 4'd7;
  localparam logic [3:0] PRD_YZ = 4'd8;
  localparam logic [3:0] PRD_XW = 4'd9;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SUMS, S_PREP, S_MUL, S_SQRT,
    S_ALOAD, S_AITER, S_ASTORE, S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PROD, OP_SUMS, OP_PREP, OP_MUL, OP_SQRT,
    OP_ALOAD, OP_ASTEP, OP_ASTORE, OP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    ANG_YAW, ANG_ROLL, ANG_PITCH
  } ang_sel_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
    ang_sel_t         sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // atan(2^-i) in Q16 centidegrees
  function automatic logic [28:0] atan_q16(input logic [4:0] i);
    logic [28:0] v;
    case (i)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183346;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      5'd24: v = 29'd22;
      5'd25: v = 29'd11;
      5'd26: v = 29'd6;
      5'd27: v = 29'd3;
      5'd28: v = 29'd1;
      5'd29: v = 29'd1;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/qte_cordic.sv
// qte_cordic: iterative CORDIC vectoring unit, one micro-rotation per step.
// Depends on qte_pkg.
module qte_cordic (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [4:0]                    shift,
  input  logic signed [qte_pkg::SW-1:0] y_in,
  input  logic signed [qte_pkg::SW-1:0] x_in,
  output logic signed [qte_pkg::AW-1:0] angle
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 frz_r, frz_nxt;
  logic signed [CW-1:0] xe, ye, dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [ZW:0]   zr;

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);
  assign dx = y_r >>> shift;
  assign dy = x_r >>> shift;
  assign at = $signed({4'b0, atan_q16(shift)});

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    frz_nxt = frz_r;
    if (load) begin
      if (ye == '0) begin
        // sine side zero: fixed answer, freeze the iterations
        frz_nxt = 1'b1;
        z_nxt   = (xe < 0) ? HALF_TURN_Q16 : '0;
      end else if (xe < 0) begin
        frz_nxt = 1'b0;
        z_nxt   = (ye > 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
        x_nxt   = -xe;
        y_nxt   = -ye;
      end else begin
        frz_nxt = 1'b0;
        z_nxt   = '0;
        x_nxt   = xe;
        y_nxt   = ye;
      end
    end else if (step && !frz_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    frz_r <= frz_nxt;
  end

  // round half up to whole centidegrees
  assign zr    = (ZW+1)'(z_r) + (ZW+1)'(32768);
  assign angle = $signed(zr[AW+15:16]);

endmodule

>>> hw/rtl/qte_datapath.sv
// qte_datapath: products, sums, pitch argument, serial multiply, square root,
// angle post-processing, heading offset and the output word register.
// Depends on qte_pkg and qte_cordic.
module qte_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qte_pkg::dp_cmd_t      cmd,
  output qte_pkg::dp_status_t   status,
  input  logic                  in_command,
  input  logic signed [15:0]    in_quat_real,
  input  logic signed [15:0]    in_quat_i,
  input  logic signed [15:0]    in_quat_j,
  input  logic signed [15:0]    in_quat_k,
  input  logic [1:0]            in_accuracy_status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_heading_centideg,
  output logic signed [14:0]    out_pitch_centideg,
  output logic signed [15:0]    out_roll_centideg,
  output logic [15:0]           out_direction_centideg,
  output logic                  out_fully_calibrated
);
  import qte_pkg::*;

  // captured word
  logic                 cmd_r;
  logic [1:0]           acc_r;
  logic signed [QW-1:0] w_r, x_r, y_r, z_r;

  logic signed [PW-1:0] prod_r [NUM_PROD];
  logic signed [QW-1:0] ma, mb;
  logic signed [PW-1:0] mp;

  logic signed [SW-1:0] yaw_y_r, yaw_x_r, roll_y_r, roll_x_r, norm_r, num_r;

  // pitch argument
  logic [32:0] d_raw, a_raw, a_sat;
  logic [31:0] pd, pa;
  logic [31:0] pa_r, m_r;
  logic [32:0] mcand_r;
  logic        neg_r;
  logic [63:0] p_r;
  logic [35:0] rem_r, rem_sh, trial;
  logic [31:0] root_r;

  logic signed [SW-1:0] cy, cx;
  logic signed [32:0]   sn;
  logic signed [AW-1:0] ang;

  logic [15:0]        yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [15:0] roll_r;
  logic [15:0]        offset_r;
  logic [15:0]        off_nxt, off_mod;
  logic [16:0]        dsum;
  logic [15:0]        dir;
  logic               out_valid_r;

  function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] v);
    return SW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      cmd_r <= in_command;
      acc_r <= in_accuracy_status;
      w_r   <= in_quat_real;
      x_r   <= in_quat_i;
      y_r   <= in_quat_j;
      z_r   <= in_quat_k;
    end
  end

  // one product a cycle through a single multiplier
  always_comb begin
    case (cmd.idx[3:0])
      PRD_WW:  begin ma = w_r; mb = w_r; end
      PRD_XX:  begin ma = x_r; mb = x_r; end
      PRD_YY:  begin ma = y_r; mb = y_r; end
      PRD_ZZ:  begin ma = z_r; mb = z_r; end
      PRD_XY:  begin ma = x_r; mb = y_r; end
      PRD_ZW:  begin ma = z_r; mb = w_r; end
      PRD_XZ:  begin ma = x_r; mb = z_r; end
      PRD_YW:  begin ma = y_r; mb = w_r; end
      PRD_YZ:  begin ma = y_r; mb = z_r; end
      PRD_XW:  begin ma = x_r; mb = w_r; end
      default: begin ma = '0;  mb = '0;  end
    endcase
  end
  assign mp = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PROD) begin
      prod_r[cmd.idx[3:0]] <= mp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SUMS) begin
      yaw_y_r  <= (sx(prod_r[PRD_XY]) + sx(prod_r[PRD_ZW])) <<< 1;
      yaw_x_r  <= sx(prod_r[PRD_XX]) - sx(prod_r[PRD_YY])
                - sx(prod_r[PRD_ZZ]) + sx(prod_r[PRD_WW]);
      roll_y_r <= (sx(prod_r[PRD_YZ]) + sx(prod_r[PRD_XW])) <<< 1;
      roll_x_r <= sx(prod_r[PRD_ZZ]) + sx(prod_r[PRD_WW])
                - sx(prod_r[PRD_XX]) - sx(prod_r[PRD_YY]);
      norm_r   <= sx(prod_r[PRD_XX]) + sx(prod_r[PRD_YY])
                + sx(prod_r[PRD_ZZ]) + sx(prod_r[PRD_WW]);
      num_r    <= (sx(prod_r[PRD_YW]) - sx(prod_r[PRD_XZ])) <<< 1;
    end
  end

  // saturate the sine numerator to the norm, halve both when the norm is large
  assign d_raw = norm_r[32:0];
  assign a_raw = num_r[SW-1] ? 33'(-num_r) : num_r[32:0];
  assign a_sat = (a_raw > d_raw) ? d_raw : a_raw;
  assign pd    = (d_raw[32] | d_raw[31]) ? d_raw[32:1] : d_raw[31:0];
  assign pa    = (d_raw[32] | d_raw[31]) ? a_sat[32:1] : a_sat[31:0];

  assign rem_sh = {rem_r[33:0], p_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PREP: begin
        pa_r    <= pa;
        neg_r   <= num_r[SW-1];
        mcand_r <= {1'b0, pd} + {1'b0, pa};
        m_r     <= pd - pa;
        p_r     <= '0;
        rem_r   <= '0;
        root_r  <= '0;
      end
      OP_MUL: begin
        // shift-add, multiplier bits MSB first
        p_r <= {p_r[62:0], 1'b0} + (m_r[31] ? {31'b0, mcand_r} : 64'b0);
        m_r <= {m_r[30:0], 1'b0};
      end
      OP_SQRT: begin
        // one result bit per step
        p_r <= {p_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign sn = neg_r ? -$signed({1'b0, pa_r}) : $signed({1'b0, pa_r});

  always_comb begin
    case (cmd.sel)
      ANG_YAW:   begin cy = yaw_y_r;  cx = yaw_x_r;  end
      ANG_ROLL:  begin cy = roll_y_r; cx = roll_x_r; end
      default:   begin cy = SW'(sn);  cx = SW'($signed({1'b0, root_r})); end
    endcase
  end

  qte_cordic u_cordic (
    .clk   (clk),
    .load  (cmd.op == OP_ALOAD),
    .step  (cmd.op == OP_ASTEP),
    .shift (cmd.idx[4:0]),
    .y_in  (cy),
    .x_in  (cx),
    .angle (ang)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ASTORE) begin
      case (cmd.sel)
        ANG_YAW:  yaw_r <= (ang < 0) ? 16'(ang + $signed({1'b0, FULL_TURN}))
                                     : 16'(ang);
        ANG_ROLL: roll_r <= (ang > 17'sd18000) ? 16'sd18000 :
                            (ang < -17'sd18000) ? -16'sd18000 : 16'(ang);
        default:  pitch_r <= (ang > 17'sd9000) ? 15'sd9000 :
                             (ang < -17'sd9000) ? -15'sd9000 : 15'(ang);
      endcase
    end
  end

  // direction = heading minus offset, wrapped
  assign off_nxt = cmd_r ? yaw_r : offset_r;
  assign off_mod = ({1'b0, off_nxt} >= FULL_TURN) ? 16'({1'b0, off_nxt} - FULL_TURN)
                                                   : off_nxt;
  assign dsum    = {1'b0, yaw_r} + FULL_TURN - {1'b0, off_mod};
  assign dir     = (dsum >= FULL_TURN) ? 16'(dsum - FULL_TURN) : dsum[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) begin
        offset_r    <= off_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_heading_centideg   <= yaw_r;
      out_pitch_centideg     <= pitch_r;
      out_roll_centideg      <= roll_r;
      out_direction_centideg <= dir;
      out_fully_calibrated   <= (acc_r == ACC_FULL);
    end
  end

  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

>>> hw/rtl/qte_ctrl.sv
// qte_ctrl: sequencer for the heading core; steps the datapath through
// products, pitch argument, square root and three angle passes.
// Depends on qte_pkg.
module qte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qte_pkg::dp_status_t status,
  output qte_pkg::dp_cmd_t    cmd
);
  import qte_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ang_sel_t         sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= ANG_YAW;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    sel_nxt   = sel_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = S_PROD;
      end
      S_PROD: begin
        if (cnt_r == CNT_W'(NUM_PROD - 1)) state_nxt = S_SUMS;
      end
      S_SUMS: state_nxt = S_PREP;
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          sel_nxt   = ANG_YAW;
          state_nxt = S_ALOAD;
        end
      end
      S_ALOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_AITER;
      end
      S_AITER: begin
        if (cnt_r == CNT_W'(ITERS - 1)) state_nxt = S_ASTORE;
      end
      S_ASTORE: begin
        case (sel_r)
          ANG_YAW:  begin sel_nxt = ANG_ROLL;  state_nxt = S_ALOAD; end
          ANG_ROLL: begin sel_nxt = ANG_PITCH; state_nxt = S_ALOAD; end
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.idx  = cnt_r;
    cmd.sel  = sel_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_PROD:   cmd.op = OP_PROD;
      S_SUMS:   cmd.op = OP_SUMS;
      S_PREP:   cmd.op = OP_PREP;
      S_MUL:    cmd.op = OP_MUL;
      S_SQRT:   cmd.op = OP_SQRT;
      S_ALOAD:  cmd.op = OP_ALOAD;
      S_AITER:  cmd.op = OP_ASTEP;
      S_ASTORE: cmd.op = OP_ASTORE;
      S_FINISH: if (status.out_free) cmd.op = OP_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/quaternion_to_euler_heading_core.sv
// quaternion_to_euler_heading_core: top level, quaternion sample in, yaw /
// pitch / roll / direction out. Depends on qte_pkg, qte_ctrl, qte_datapath.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready   | command, four Q14 components, status
//   out_    | output    | out_valid / out_ready | heading, pitch, roll, direction, calib
//
// Sequence: a word is taken while idle, then 10 products on one 16x16
//   multiplier, the sums, the pitch setup, 32 shift-add steps for the pitch
//   cosine product, 32 square-root steps, three passes of the shared CORDIC
//   unit (load, iterations, store) and the result load; a new word is
//   taken only after the result load of the word before it.
// Reset: rst_n low clears the sequencer, the output valid and the zero offset.
// Stalls: a finished result waits in the output register; the next word is
//   taken while it waits, and the core holds before its own result load
//   only if the previous result is still not taken.
module quaternion_to_euler_heading_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_quat_real,
  input  logic signed [15:0] in_quat_i,
  input  logic signed [15:0] in_quat_j,
  input  logic signed [15:0] in_quat_k,
  input  logic [1:0]         in_accuracy_status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_heading_centideg,
  output logic signed [14:0] out_pitch_centideg,
  output logic signed [15:0] out_roll_centideg,
  output logic [15:0]        out_direction_centideg,
  output logic               out_fully_calibrated
);
  import qte_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: one word at a time
  qte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, offset register and output word register
  qte_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_command             (in_command),
    .in_quat_real           (in_quat_real),
    .in_quat_i              (in_quat_i),
    .in_quat_j              (in_quat_j),
    .in_quat_k              (in_quat_k),
    .in_accuracy_status     (in_accuracy_status),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_heading_centideg   (out_heading_centideg),
    .out_pitch_centideg     (out_pitch_centideg),
    .out_roll_centideg      (out_roll_centideg),
    .out_direction_centideg (out_direction_centideg),
    .out_fully_calibrated   (out_fully_calibrated)
  );

endmodule

>>> hw/rtl/qte_checker.sv
// qte_checker: port-level assertions for the heading core, bound to the top
// level. Depends only on the top level's ports.
module qte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_heading_centideg,
  input logic signed [14:0] out_pitch_centideg,
  input logic signed [15:0] out_roll_centideg,
  input logic [15:0]        out_direction_centideg
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading_centideg)
      && $stable(out_direction_centideg) && $stable(out_pitch_centideg))
    else $error("stalled result word changed");

  // drop ready right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_centideg < 16'd36000
      && out_direction_centideg < 16'd36000)
    else $error("heading or direction out of range");

  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_centideg <= 15'sd9000 && out_pitch_centideg >= -15'sd9000
      && out_roll_centideg <= 16'sd18000 && out_roll_centideg >= -16'sd18000)
    else $error("pitch or roll out of range");

endmodule

bind quaternion_to_euler_heading_core qte_checker u_qte_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_heading_centideg   (out_heading_centideg),
  .out_pitch_centideg     (out_pitch_centideg),
  .out_roll_centideg      (out_roll_centideg),
  .out_direction_centideg (out_direction_centideg)
);

>>> sim/quaternion_to_euler_heading_core_test.sv
// quaternion_to_euler_heading_core_test: self-checking bench for the quaternion to
// Euler heading core; predicts yaw, pitch, roll and direction per word and checks
// them in order. Depends on qte_pkg and quaternion_to_euler_heading_core.
`timescale 1ns / 100ps

module quaternion_to_euler_heading_core_test;
  import qte_pkg::*;

  localparam int TURN_CDEG   = 36000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 900;
  localparam bit CMD_SAMPLE   = 1'b0;
  localparam bit CMD_SET_ZERO = 1'b1;

  typedef struct {
    bit               command;
    logic signed [15:0] w, x, y, z;
    logic [1:0]       status;
  } quat_word_t;

  typedef struct {
    logic [15:0]        heading;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic [15:0]        direction;
    logic               calibrated;
  } euler_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = 1'b0;
  logic signed [15:0] in_quat_real = '0;
  logic signed [15:0] in_quat_i = '0;
  logic signed [15:0] in_quat_j = '0;
  logic signed [15:0] in_quat_k = '0;
  logic [1:0]         in_accuracy_status = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_heading_centideg;
  logic signed [14:0] out_pitch_centideg;
  logic signed [15:0] out_roll_centideg;
  logic [15:0]        out_direction_centideg;
  logic               out_fully_calibrated;

  quat_word_t  pending_words[$];
  euler_word_t expected_angles[$];
  quat_word_t  driven_word;
  logic [15:0] zero_offset;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          send_burst = 0;
  bit          recv_burst = 0;

  // atan(2^-i) in Q16 centidegrees
  longint atan_steps[32] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0};

  quaternion_to_euler_heading_core i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Vectoring-mode angle, rounded half up to whole centidegrees
  function automatic longint vector_angle(longint sin_part, longint cos_part);
    longint angle_acc;
    longint dx;
    longint dy;
    angle_acc = 0;
    if (sin_part == 0) return (cos_part < 0) ? 18000 : 0;
    if (cos_part < 0) begin
      angle_acc = (sin_part > 0) ? 64'sd1179648000 : -64'sd1179648000;
      cos_part = -cos_part;
      sin_part = -sin_part;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = sin_part >>> i;
      dy = cos_part >>> i;
      if (sin_part > 0) begin
        cos_part += dx;
        sin_part -= dy;
        angle_acc += atan_steps[i & 31];
      end else begin
        cos_part -= dx;
        sin_part += dy;
        angle_acc -= atan_steps[i & 31];
      end
    end
    return (angle_acc + 32768) >>> 16;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  // Work out the angles of one word; sets the zero offset to the heading on set-zero
  function automatic euler_word_t predict_angles(quat_word_t q);
    euler_word_t r;
    longint w, x, y, z, ww, xx, yy, zz, norm, num, yaw, pitch, roll;
    longint unsigned den, mag, cosv;
    w = q.w; x = q.x; y = q.y; z = q.z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    norm = ww + xx + yy + zz;
    num = -2 * (x * z - y * w);
    yaw = vector_angle(2 * (x * y + z * w), xx - yy - zz + ww);
    while (yaw < 0) yaw += TURN_CDEG;
    while (yaw >= TURN_CDEG) yaw -= TURN_CDEG;
    roll = clip(vector_angle(2 * (y * z + x * w), -xx - yy + zz + ww), 18000);
    if (norm == 0) begin
      pitch = 0;
    end else begin
      den = norm;
      mag = (num < 0) ? -num : num;
      if (mag > den) mag = den;
      if (den >= (64'd1 << 31)) begin
        den >>= 1;
        mag >>= 1;
      end
      cosv = floor_sqrt((den - mag) * (den + mag));
      pitch = clip(vector_angle((num < 0) ? -longint'(mag) : longint'(mag),
                                longint'(cosv)), 9000);
    end
    if (q.command == CMD_SET_ZERO) zero_offset = yaw[15:0];
    r.heading = yaw[15:0];
    r.pitch = pitch[14:0];
    r.roll = roll[15:0];
    r.direction = 16'((yaw + TURN_CDEG - (zero_offset % TURN_CDEG)) % TURN_CDEG);
    r.calibrated = (q.status == ACC_FULL);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
  endtask

  function automatic void queue_word(bit cmd, int w, int x, int y, int z, int st);
    quat_word_t q;
    q.command = cmd;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    q.status = 2'(st);
    pending_words.push_back(q);
  endfunction

  // Driver: hold the word until taken, then draw a gap before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_angles.push_back(predict_angles(driven_word));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          driven_word = pending_words.pop_front();
          in_command <= driven_word.command;
          in_quat_real <= driven_word.w;
          in_quat_i <= driven_word.x;
          in_quat_j <= driven_word.y;
          in_quat_k <= driven_word.z;
          in_accuracy_status <= driven_word.status;
          in_valid <= 1'b1;
          if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    euler_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result word", int'(out_heading_centideg), -1);
        end else begin
          e = expected_angles.pop_front();
          if (out_heading_centideg !== e.heading)
            report_mismatch("heading", int'(out_heading_centideg), int'(e.heading));
          if (out_pitch_centideg !== e.pitch)
            report_mismatch("pitch", int'(out_pitch_centideg), int'(e.pitch));
          if (out_roll_centideg !== e.roll)
            report_mismatch("roll", int'(out_roll_centideg), int'(e.roll));
          if (out_direction_centideg !== e.direction)
            report_mismatch("direction", int'(out_direction_centideg),
                            int'(e.direction));
          if (out_fully_calibrated !== e.calibrated)
            report_mismatch("fully_calibrated", int'(out_fully_calibrated),
                            int'(e.calibrated));
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
        if (out_valid) recv_stall <= recv_burst ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // Watchdog: fail and end the run once the cycle limit is reached, as when the core stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int mode;
    zero_offset = '0;
    // Directed: zero norm, axes, extremes, set-zero, negative-cosine cases
    queue_word(CMD_SAMPLE, 0, 0, 0, 0, 0);
    queue_word(CMD_SAMPLE, 16384, 0, 0, 0, 3);
    queue_word(CMD_SAMPLE, 0, 16384, 0, 0, 1);
    queue_word(CMD_SAMPLE, 0, 0, 16384, 0, 2);
    queue_word(CMD_SAMPLE, 0, 0, 0, 16384, 3);
    queue_word(CMD_SAMPLE, -32768, -32768, -32768, -32768, 0);
    queue_word(CMD_SAMPLE, 32767, 32767, 32767, 32767, 3);
    queue_word(CMD_SAMPLE, 32767, -32768, 32767, -32768, 2);
    queue_word(CMD_SAMPLE, -32768, 32767, 32767, -32768, 1);
    queue_word(CMD_SAMPLE, 11585, 0, 11585, 0, 3);
    queue_word(CMD_SAMPLE, 11585, 0, -11585, 0, 3);
    queue_word(CMD_SAMPLE, 11585, 11585, 0, 0, 0);
    queue_word(CMD_SAMPLE, 11585, 0, 0, 11585, 3);
    queue_word(CMD_SET_ZERO, 11585, 0, 0, 11585, 3);
    queue_word(CMD_SAMPLE, 16384, 0, 0, 0, 3);
    queue_word(CMD_SAMPLE, 0, 0, 0, -16384, 2);
    queue_word(CMD_SET_ZERO, 14189, 0, 0, -8192, 3);
    queue_word(CMD_SAMPLE, 1, 0, 0, 0, 0);
    queue_word(CMD_SAMPLE, 0, 0, 0, -1, 1);
    queue_word(CMD_SAMPLE, -1, 1, -1, 1, 2);
    queue_word(CMD_SET_ZERO, 0, 0, 0, 0, 3);
    queue_word(CMD_SAMPLE, 5000, -3000, 2000, 15000, 3);
    // Random: mostly full range, some small magnitudes and sparse components
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quat_word_t q;
      mode = $urandom_range(0, 9);
      q.command = ($urandom_range(0, 7) == 0) ? CMD_SET_ZERO : CMD_SAMPLE;
      q.status = 2'($urandom_range(0, 3));
      q.w = 16'($urandom); q.x = 16'($urandom);
      q.y = 16'($urandom); q.z = 16'($urandom);
      if (mode == 0) begin
        q.w = $signed(q.w) >>> 12; q.x = $signed(q.x) >>> 12;
        q.y = $signed(q.y) >>> 12; q.z = $signed(q.z) >>> 12;
      end else if (mode == 1) begin
        if ($urandom_range(0, 1)) q.w = 0;
        if ($urandom_range(0, 1)) q.x = 0;
        if ($urandom_range(0, 1)) q.y = 0;
        if ($urandom_range(0, 1)) q.z = 0;
      end
      pending_words.push_back(q);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_angles.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_angles.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
